>>> rtl/gf2m_inverse_ext_euclid_core_macros.svh
// assertion macros used by the checker file of the gf2m inverse core
// depends on nothing; included by bare file name
`ifndef GF2M_INVERSE_EXT_EUCLID_CORE_MACROS_SVH
`define GF2M_INVERSE_EXT_EUCLID_CORE_MACROS_SVH

// same-cycle implication, reset masks the check
`define GIE_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define GIE_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gie_pkg.sv
// shared constants for the gf2m inverse core and its checker
// depends on nothing
package gie_pkg;

	// default field degree and modulus after reset (x^10 + x^3 + 1)
	localparam int FIELD_DEGREE_DEF = 10;
	localparam int MODULUS_RESET    = 1033;

endpackage

>>> rtl/gf2m_inverse_ext_euclid_core.sv
// gf2m inverse core: multiplicative inverse in GF(2^m) by extended euclid
// depends on gie_pkg for default parameter values
//
// Takes one field element on start (accepted when start is high and busy is
// low) and later shows its inverse on inverse, marked by done, which is high
// for exactly one cycle. There is no back-pressure on the result side: the
// receiver must take inverse in the cycle done is high. busy goes high in the
// cycle after a request is accepted and drops in the cycle done is shown; a new
// request may be accepted in the done cycle itself. One request runs as a
// series of steps of a single shift-and-xor unit: each step either cancels the
// leading term of the running remainder (and updates the bezout coefficient
// with the same shift) or swaps the remainder pair at the end of a division
// round. A zero element finishes on the first step and returns zero.
// The modulus polynomial is written over the cfg_valid/cfg_ready channel and
// is accepted only while busy is low. With a reducible modulus the result is
// the bezout coefficient of the gcd, returned without any flag.
module gf2m_inverse_ext_euclid_core #(
	parameter int FIELD_DEGREE = gie_pkg::FIELD_DEGREE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request side
	input  logic                    start,
	input  logic [FIELD_DEGREE-1:0] element,
	output logic                    busy,
	// result side
	output logic                    done,
	output logic [FIELD_DEGREE-1:0] inverse,
	// modulus register write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [FIELD_DEGREE:0]   modulus_poly
);

	// all polynomials fit in degree FIELD_DEGREE
	localparam int W  = FIELD_DEGREE + 1;
	localparam int DW = $clog2(W);
	localparam logic [W-1:0] MOD_RST = W'(gie_pkg::MODULUS_RESET);

	// sequencer codes
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	// leading-term position of a nonzero polynomial
	function automatic logic [DW-1:0] poly_deg(input logic [W-1:0] p);
		logic [DW-1:0] d;
		d = '0;
		for (int i = 0; i < W; i++) begin
			if (p[i]) begin
				d = DW'(i);
			end
		end
		return d;
	endfunction

	logic           state_q;
	logic [W-1:0]   modulus_q;
	// rp_q: dividend being reduced, rc_q: divisor of the current round
	logic [W-1:0]   rp_q, rc_q;
	// bezout coefficients paired with rp_q and rc_q
	logic [W-1:0]   tp_q, tc_q;
	logic           done_q;
	logic [FIELD_DEGREE-1:0] inverse_q;

	logic [DW-1:0]  deg_p, deg_c, shamt;
	logic           do_reduce;
	logic [W-1:0]   rp_red, tp_red;

	assign busy      = (state_q == ST_RUN);
	assign cfg_ready = (state_q == ST_IDLE);
	assign done      = done_q;
	assign inverse   = inverse_q;

	// the shared shift-and-xor unit
	always_comb begin
		deg_p     = poly_deg(rp_q);
		deg_c     = poly_deg(rc_q);
		// division round continues while rp still reaches the divisor degree
		do_reduce = (rp_q != '0) && (deg_p >= deg_c);
		shamt     = deg_p - deg_c;
		rp_red    = rp_q ^ (rc_q << shamt);
		tp_red    = tp_q ^ (tc_q << shamt);
	end

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= modulus_poly;
		end
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// finish when the divisor is zero or the round leaves zero
					if (rc_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else if (!do_reduce && (rp_q == '0)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					rp_q <= modulus_q;
					rc_q <= W'(element);
					tp_q <= '0;
					tc_q <= W'(1);
				end
			end
			ST_RUN: begin
				if (rc_q == '0) begin
					// zero element: nothing to invert
					inverse_q <= tp_q[FIELD_DEGREE-1:0];
				end else if (do_reduce) begin
					rp_q <= rp_red;
					tp_q <= tp_red;
				end else begin
					// round done: remainder becomes the next divisor
					rp_q <= rc_q;
					rc_q <= rp_q;
					tp_q <= tc_q;
					tc_q <= tp_q;
					inverse_q <= tc_q[FIELD_DEGREE-1:0];
				end
			end
			default: begin
				rp_q <= rp_q;
			end
		endcase
	end

endmodule

>>> rtl/gie_checker.sv
// port-level checker for the gf2m inverse core, bound to the top level
// depends on gie_pkg and gf2m_inverse_ext_euclid_core_macros.svh
`include "gf2m_inverse_ext_euclid_core_macros.svh"

module gie_checker #(
	parameter int FIELD_DEGREE = gie_pkg::FIELD_DEGREE_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic                    cfg_valid,
	input logic                    cfg_ready
);

	// an accepted request always occupies the core next cycle
	`GIE_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "request accepted but core not busy")

	// the result strobe lasts one cycle only
	`GIE_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done, "done held longer than one cycle")

	// busy ends exactly when a result is shown
	`GIE_ASSERT_IMP(a_busy_end, clk, arst_n, $fell(busy), done, "busy dropped without a result")

	// no result without a request in flight
	`GIE_ASSERT_IMP(a_done_src, clk, arst_n, done, $past(busy) && !busy, "result without request")

	// the modulus is only taken while the core is idle
	`GIE_ASSERT_IMP(a_cfg_idle, clk, arst_n, cfg_valid && cfg_ready, !busy, "modulus written while busy")

endmodule

bind gf2m_inverse_ext_euclid_core gie_checker #(
	.FIELD_DEGREE(FIELD_DEGREE)
) u_gie_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
